// ===== hdl/pht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types and constants for the homogeneous point transform unit.
// ----------------------------------------------------------------------------
package pht_pkg;

    localparam int COORD_W  = 32;
    localparam int QBITS    = 32;
    localparam int LANES    = 3;
    localparam int ROWS     = 4;
    localparam int NCOEF    = 16;
    localparam int COLS     = 4;
    // product width (64) plus two bits of sum growth; row width is this minus FRAC_BITS
    localparam int ACC_SPAN = 66;

    localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] NEG_MIN = 32'h8000_0000;

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_XFORM = 1'b1
    } action_t;

endpackage : pht_pkg
`default_nettype wire

// ===== hdl/pht_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pht_in_if
// Input channel: coefficient load or point transform transaction.
// ----------------------------------------------------------------------------
interface pht_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source
    (
        output valid, action, coef_index, coef_value, point_x, point_y, point_z,
        input  ready
    );

    modport sink
    (
        input  valid, action, coef_index, coef_value, point_x, point_y, point_z,
        output ready
    );
endinterface : pht_in_if
`default_nettype wire

// ===== hdl/pht_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pht_out_if
// Output channel: transformed point after the perspective divide.
// ----------------------------------------------------------------------------
interface pht_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               saturated;

    modport source
    (
        output valid, out_x, out_y, out_z, w_zero, saturated,
        input  ready
    );

    modport sink
    (
        input  valid, out_x, out_y, out_z, w_zero, saturated,
        output ready
    );
endinterface : pht_out_if
`default_nettype wire

// ===== hdl/pht_dot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pht_dot
// Coefficient store and four row dot products, three pipeline stages.
// ----------------------------------------------------------------------------
module pht_dot #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pht_in_if.sink    pt_in,
    output logic      row_valid,
    input  wire logic row_ready,
    output logic signed [pht_pkg::ACC_SPAN-FRAC_BITS-1:0] row [pht_pkg::ROWS]
);
    import pht_pkg::*;

    localparam int RW = ACC_SPAN - FRAC_BITS;

    logic signed [COORD_W-1:0]   coef_reg [NCOEF];
    logic signed [2*COORD_W-1:0] prod_reg [ROWS][LANES];
    logic signed [2*COORD_W-1:0] prod_next [ROWS][LANES];
    logic signed [COORD_W-1:0]   bias_reg [ROWS];
    logic signed [RW-1:0]        sa_reg [ROWS];
    logic signed [RW-1:0]        sb_reg [ROWS];
    logic signed [RW-1:0]        row_reg [ROWS];
    logic signed [COORD_W-1:0]   pt [LANES];
    logic [2:0]                  vld_reg;
    logic [2:0]                  adv;
    logic                        take_xform;
    logic                        take_load;

    assign pt[0] = pt_in.point_x;
    assign pt[1] = pt_in.point_y;
    assign pt[2] = pt_in.point_z;

    always_comb
    begin
        adv[2] = !vld_reg[2] || row_ready;
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign pt_in.ready = adv[0];
    assign take_load   = pt_in.valid && adv[0] && (pt_in.action == ACT_LOAD);
    assign take_xform  = pt_in.valid && (pt_in.action == ACT_XFORM);

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_next[r][c] = coef_reg[r*COLS+c] * pt[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            if (take_load)
            begin
                coef_reg[pt_in.coef_index] <= pt_in.coef_value;
            end
            if (adv[0])
            begin
                vld_reg[0] <= take_xform;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            if (adv[0])
            begin
                for (int c = 0; c < LANES; c++)
                begin
                    prod_reg[r][c] <= prod_next[r][c];
                end
                bias_reg[r] <= coef_reg[r*COLS+LANES];
            end
            if (adv[1])
            begin
                sa_reg[r] <= RW'(prod_reg[r][0] >>> FRAC_BITS)
                           + RW'(prod_reg[r][1] >>> FRAC_BITS);
                sb_reg[r] <= RW'(prod_reg[r][2] >>> FRAC_BITS) + RW'(bias_reg[r]);
            end
            if (adv[2])
            begin
                row_reg[r] <= sa_reg[r] + sb_reg[r];
            end
        end
    end

    assign row_valid = vld_reg[2];
    assign row       = row_reg;

endmodule : pht_dot
`default_nettype wire

// ===== hdl/pht_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pht_div
// Perspective divide: three lanes of pipelined restoring division by w,
// one quotient bit per stage, then clamp into the output register.
// ----------------------------------------------------------------------------
module pht_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic row_valid,
    output logic      row_ready,
    input  wire logic signed [pht_pkg::ACC_SPAN-FRAC_BITS-1:0] row [pht_pkg::ROWS],
    pht_out_if.source pt_out
);
    import pht_pkg::*;

    localparam int RW = ACC_SPAN - FRAC_BITS;
    localparam int LS = QBITS + 1;
    localparam int NS = QBITS + 2;

    logic [RW-1:0]       n0_reg [LANES];
    logic                neg0_reg [LANES];
    logic [RW-1:0]       d0_reg;
    logic                wz0_reg;

    logic [RW-1:0]       rem_reg [1:LS][LANES];
    logic [QBITS-1:0]    q_reg [1:LS][LANES];
    logic [QBITS-1:0]    lo_reg [1:LS][LANES];
    logic                ovr_reg [1:LS][LANES];
    logic                neg_reg [1:LS][LANES];
    logic [RW-1:0]       d_reg [1:LS];
    logic                wz_reg [1:LS];

    logic [RW-1:0]       rem_next [1:LS][LANES];
    logic [QBITS-1:0]    q_next [1:LS][LANES];
    logic [QBITS-1:0]    lo_next [1:LS][LANES];
    logic                ovr_next [1:LS][LANES];

    logic [RW-1:0]       n_abs [LANES];
    logic [RW-1:0]       w_abs;
    logic                w_is_zero;
    logic [ACC_SPAN-1:0] nf;
    logic [RW-1:0]       hi;
    logic [RW:0]         trial;
    logic [RW:0]         dd;
    logic [COORD_W-1:0]  res [LANES];
    logic [LANES-1:0]    clip;

    logic [NS-1:0]       vld_reg;
    logic [NS:0]         adv;
    logic                out_vld_reg;
    logic signed [COORD_W-1:0] ox_reg, oy_reg, oz_reg;
    logic                wz_out_reg;
    logic                sat_out_reg;

    always_comb
    begin
        adv[NS] = !out_vld_reg || pt_out.ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign row_ready = adv[0];

    always_comb
    begin
        w_is_zero = (row[ROWS-1] == '0);
        w_abs     = row[ROWS-1][RW-1] ? RW'(-row[ROWS-1]) : RW'(row[ROWS-1]);
        for (int l = 0; l < LANES; l++)
        begin
            n_abs[l] = row[l][RW-1] ? RW'(-row[l]) : RW'(row[l]);
        end
    end

    // initial remainder and overflow check, then one quotient bit per stage
    always_comb
    begin
        nf    = '0;
        hi    = '0;
        trial = '0;
        dd    = '0;
        for (int l = 0; l < LANES; l++)
        begin
            nf             = {n0_reg[l], {FRAC_BITS{1'b0}}};
            hi             = RW'(nf[ACC_SPAN-1:QBITS]);
            ovr_next[1][l] = (hi >= d0_reg);
            rem_next[1][l] = ovr_next[1][l] ? '0 : hi;
            lo_next[1][l]  = nf[QBITS-1:0];
            q_next[1][l]   = '0;
        end
        for (int s = 2; s <= LS; s++)
        begin
            dd = {1'b0, d_reg[s-1]};
            for (int l = 0; l < LANES; l++)
            begin
                trial          = {rem_reg[s-1][l], lo_reg[s-1][l][LS-s]};
                ovr_next[s][l] = ovr_reg[s-1][l];
                lo_next[s][l]  = lo_reg[s-1][l];
                if (trial >= dd)
                begin
                    rem_next[s][l] = RW'(trial - dd);
                    q_next[s][l]   = {q_reg[s-1][l][QBITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][l] = RW'(trial);
                    q_next[s][l]   = {q_reg[s-1][l][QBITS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (neg_reg[LS][l])
            begin
                clip[l] = ovr_reg[LS][l] || (q_reg[LS][l] > NEG_MIN);
                res[l]  = clip[l] ? NEG_MIN : COORD_W'(-q_reg[LS][l]);
            end
            else
            begin
                clip[l] = ovr_reg[LS][l] || q_reg[LS][l][QBITS-1];
                res[l]  = clip[l] ? POS_MAX : q_reg[LS][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= row_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (adv[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
            if (adv[NS])
            begin
                out_vld_reg <= vld_reg[NS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d0_reg  <= w_is_zero ? (RW'(1) << FRAC_BITS) : w_abs;
            wz0_reg <= w_is_zero;
            for (int l = 0; l < LANES; l++)
            begin
                n0_reg[l]   <= n_abs[l];
                neg0_reg[l] <= row[l][RW-1] ^ row[ROWS-1][RW-1];
            end
        end
        if (adv[1])
        begin
            d_reg[1]  <= d0_reg;
            wz_reg[1] <= wz0_reg;
            for (int l = 0; l < LANES; l++)
            begin
                neg_reg[1][l] <= neg0_reg[l];
            end
        end
        for (int s = 2; s <= LS; s++)
        begin
            if (adv[s])
            begin
                d_reg[s]  <= d_reg[s-1];
                wz_reg[s] <= wz_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    neg_reg[s][l] <= neg_reg[s-1][l];
                end
            end
        end
        for (int s = 1; s <= LS; s++)
        begin
            if (adv[s])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                    lo_reg[s][l]  <= lo_next[s][l];
                    ovr_reg[s][l] <= ovr_next[s][l];
                end
            end
        end
        if (adv[NS])
        begin
            ox_reg      <= res[0];
            oy_reg      <= res[1];
            oz_reg      <= res[2];
            wz_out_reg  <= wz_reg[LS];
            sat_out_reg <= |clip;
        end
    end

    assign pt_out.valid     = out_vld_reg;
    assign pt_out.out_x     = ox_reg;
    assign pt_out.out_y     = oy_reg;
    assign pt_out.out_z     = oz_reg;
    assign pt_out.w_zero    = wz_out_reg;
    assign pt_out.saturated = sat_out_reg;

    a_div_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> d0_reg != '0)
        else $error("divisor is zero in first divide stage");

    a_wz_one : assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && wz0_reg) |-> d0_reg == (RW'(1) << FRAC_BITS))
        else $error("zero w not replaced by one");

    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] |-> rem_reg[LS][0] < d_reg[LS])
        else $error("partial remainder not below divisor");

endmodule : pht_div
`default_nettype wire

// ===== hdl/homogeneous_point_transform_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// homogeneous_point_transform_unit
// 4x4 homogeneous transform of a Q16.16 point with perspective divide.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is taken every cycle unless a held-off output
// has stalled the pipeline back to the input. A transform result passes 3 stages
// of multiply and row sum, 34 stages of divide (an input register and a remainder
// setup stage, then one quotient bit per stage) and 1 output register. A
// coefficient load gives no result and is seen by every point taken after it.
// Stalls back up stage by stage, so bubbles are squeezed out before the input is held off.
module homogeneous_point_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pht_in_if.sink    pt_in,
    pht_out_if.source pt_out
);
    import pht_pkg::*;

    logic                                        row_valid;
    logic                                        row_ready;
    logic signed [ACC_SPAN-FRAC_BITS-1:0]        row [ROWS];

    pht_dot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_in     (pt_in),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row)
    );

    pht_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row),
        .pt_out    (pt_out)
    );

endmodule : homogeneous_point_transform_unit
`default_nettype wire
